// ===== hdl/nrb_pkg.sv =====
// ----------------------------------------------------------------------------
// nrb_pkg
// Shared types and constants for the adapter ring bookkeeping block: command
// and outcome codes, link speed codes, config indices, the input and result words, and ring geometry.
// ----------------------------------------------------------------------------
package nrb_pkg;

  localparam int NUM_DESC = 4;
  localparam int IDX_W    = $clog2(NUM_DESC);
  localparam int CNT_W    = $clog2(NUM_DESC + 1);

  localparam int RING_W         = 17;
  localparam int RING_BASE      = 8192;
  localparam logic [15:0] COPYING_MARK = 16'hFFF0;
  localparam logic [15:0] RX_HDR_LEN   = 16'd4;
  localparam logic [15:0] PTR_BACKOFF  = 16'd16;
  localparam logic [5:0]  THRESH_START = 6'd4;
  localparam logic [1:0]  RING_CODE_RST   = 2'd3;
  localparam logic [5:0]  THRESH_LIMIT_RST = 6'd47;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    CMD_TX_ENQ    = 3'd0,
    CMD_TX_STATUS = 3'd1,
    CMD_RX_HEADER = 3'd2,
    CMD_LOAD_PTR  = 3'd3,
    CMD_LINK      = 3'd4,
    CMD_REINIT    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_DONE       = 3'd0,
    OUT_RING_FULL  = 3'd1,
    OUT_NONE_DONE  = 3'd2,
    OUT_COPYING    = 3'd3,
    OUT_RX_RESET   = 3'd4,
    OUT_NO_CHANGE  = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    SPEED_UNKNOWN = 2'd0,
    SPEED_10      = 2'd1,
    SPEED_100     = 2'd2
  } speed_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] pkt_size;
    logic [1:0]  addr_low;
    logic [31:0] tx_word;
    logic [15:0] rx_status;
    logic [15:0] rx_length;
    logic [15:0] pointer_value;
    logic [7:0]  media_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [1:0]  desc_index;
    logic [21:0] tsd_word;
    logic        in_place;
    logic        tx_error;
    logic [15:0] data_offset;
    logic [15:0] first_len;
    logic [15:0] second_len;
    logic [15:0] pointer_write;
    logic [2:0]  error_class;
    logic        speed_changed;
    logic        speed_fast;
  } out_item_t;

endpackage

// ===== hdl/nic_ring_bookkeeping_core.sv =====
// ----------------------------------------------------------------------------
// nic_ring_bookkeeping_core
// Host-side bookkeeping for a transmit descriptor ring and a receive byte ring.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  nrb_pkg::in_item_t
//   out_     output     out_valid/out_ready nrb_pkg::out_item_t
//   cfg_     input      cfg_wr_en          cfg_index, cfg_wdata
//
// An accepted word sits in the input register and, as soon as the result
// register is free, is decoded, applied to the ring state and captured in the
// result register. With no stall, a word passes through the input register and
// then the result register; one word per cycle is sustained while out_ready stays high. The input register keeps
// loading while a result waits if it is empty, and stalls only when both registers are full
// and out_ready is low. Reset is synchronous and returns the valid flags, configuration and ring
// state to their initial values.
// ----------------------------------------------------------------------------
module nic_ring_bookkeeping_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  nrb_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output nrb_pkg::out_item_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [nrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nrb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic               s1_valid_r, s1_valid_nxt;
  nrb_pkg::in_item_t  s1_item_r;
  logic               out_valid_r, out_valid_nxt;
  nrb_pkg::out_item_t out_item_r, res_mux;
  nrb_pkg::out_item_t tx_res, rx_res, link_res;
  logic [1:0]         ring_code_r;
  logic [5:0]         thr_limit_r;
  logic               adv, fire;

  assign adv       = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && adv;
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  nrb_tx u_tx (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .item            (s1_item_r),
    .threshold_limit (thr_limit_r),
    .res             (tx_res)
  );

  nrb_rx u_rx (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (s1_item_r),
    .ring_size_code (ring_code_r),
    .res            (rx_res)
  );

  nrb_link u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .res   (link_res)
  );

  always_comb begin
    res_mux = '0;
    res_mux.outcome = nrb_pkg::OUT_NO_CHANGE;
    case (s1_item_r.cmd)
      nrb_pkg::CMD_TX_ENQ, nrb_pkg::CMD_TX_STATUS, nrb_pkg::CMD_REINIT: begin
        res_mux = tx_res;
      end
      nrb_pkg::CMD_RX_HEADER, nrb_pkg::CMD_LOAD_PTR: begin
        res_mux = rx_res;
      end
      nrb_pkg::CMD_LINK: begin
        res_mux = link_res;
      end
      default: begin
        res_mux.outcome = nrb_pkg::OUT_NO_CHANGE;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ring_code_r <= nrb_pkg::RING_CODE_RST;
      thr_limit_r <= nrb_pkg::THRESH_LIMIT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          nrb_pkg::CFG_RING_SIZE: begin
            ring_code_r <= cfg_wdata[1:0];
          end
          nrb_pkg::CFG_THRESH_LIMIT: begin
            thr_limit_r <= cfg_wdata[5:0];
          end
          default: begin
            ring_code_r <= ring_code_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= res_mux;
    end
  end

endmodule

// ===== hdl/nrb_tx.sv =====
// ----------------------------------------------------------------------------
// nrb_tx
// Transmit descriptor ring: claims descriptors on enqueue, retires the oldest
// on a status word, tunes the early transmit threshold on underrun, and resets on reinit.
// ----------------------------------------------------------------------------
module nrb_tx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  nrb_pkg::in_item_t item,
  input  logic [5:0]        threshold_limit,
  output nrb_pkg::out_item_t res
);

  logic [nrb_pkg::IDX_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [nrb_pkg::CNT_W-1:0]    busy_r, busy_nxt;
  logic [5:0]                   thr_r, thr_nxt;
  logic [nrb_pkg::NUM_DESC-1:0] held_r, held_nxt;
  logic full, retire_ok, aligned;
  logic [nrb_pkg::IDX_W-1:0] head_inc, tail_inc;

  assign full      = (busy_r == nrb_pkg::CNT_W'(nrb_pkg::NUM_DESC));
  assign retire_ok = (busy_r != '0) &&
                     (item.tx_word[30] || item.tx_word[15] || item.tx_word[14]);
  assign aligned   = (item.addr_low == 2'd0);
  assign head_inc  = (head_r == nrb_pkg::IDX_W'(nrb_pkg::NUM_DESC - 1)) ?
                     '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == nrb_pkg::IDX_W'(nrb_pkg::NUM_DESC - 1)) ?
                     '0 : tail_r + 1'b1;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    busy_nxt = busy_r;
    thr_nxt  = thr_r;
    held_nxt = held_r;
    res      = '0;
    res.outcome = nrb_pkg::OUT_NO_CHANGE;
    case (item.cmd)
      nrb_pkg::CMD_TX_ENQ: begin
        if (full) begin
          res.outcome = nrb_pkg::OUT_RING_FULL;
        end else begin
          res.outcome    = nrb_pkg::OUT_DONE;
          res.desc_index = 2'(head_r);
          res.tsd_word   = {thr_r, 3'b000, item.pkt_size};
          res.in_place   = aligned;
          if (fire) begin
            held_nxt[head_r] = aligned;
            busy_nxt = busy_r + 1'b1;
            head_nxt = head_inc;
          end
        end
      end
      nrb_pkg::CMD_TX_STATUS: begin
        if (!retire_ok) begin
          res.outcome = nrb_pkg::OUT_NONE_DONE;
        end else begin
          res.outcome    = nrb_pkg::OUT_DONE;
          res.desc_index = 2'(tail_r);
          res.in_place   = held_r[tail_r];
          res.tx_error   = !item.tx_word[15];
          if (fire) begin
            if (!item.tx_word[15] && item.tx_word[14] && (thr_r < threshold_limit)) begin
              thr_nxt = thr_r + 1'b1;
            end
            held_nxt[tail_r] = 1'b0;
            busy_nxt = busy_r - 1'b1;
            tail_nxt = tail_inc;
          end
        end
      end
      nrb_pkg::CMD_REINIT: begin
        res.outcome = nrb_pkg::OUT_DONE;
        if (fire) begin
          head_nxt = '0;
          tail_nxt = '0;
          busy_nxt = '0;
          thr_nxt  = nrb_pkg::THRESH_START;
          held_nxt = '0;
        end
      end
      default: begin
        res.outcome = nrb_pkg::OUT_NO_CHANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      busy_r <= '0;
      thr_r  <= nrb_pkg::THRESH_START;
      held_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      busy_r <= busy_nxt;
      thr_r  <= thr_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== hdl/nrb_rx.sv =====
// ----------------------------------------------------------------------------
// nrb_rx
// Receive ring read pointer: splits a packet at the ring wrap, advances and
// rounds the read offset, loads it from a pointer value, and classifies bad headers.
// ----------------------------------------------------------------------------
module nrb_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  nrb_pkg::in_item_t item,
  input  logic [1:0]        ring_size_code,
  output nrb_pkg::out_item_t res
);

  logic [15:0] rd_off_r, rd_off_nxt;
  logic [nrb_pkg::RING_W-1:0] ring_len, sum, seg, rnd_sum, load_sum, off_sum;
  logic [15:0] mask, off, next_off, rounded, load_off;
  logic wrap;
  logic [2:0] ec;

  assign ring_len = nrb_pkg::RING_W'(nrb_pkg::RING_BASE) << ring_size_code;
  assign mask     = 16'(ring_len - 1'b1);
  assign off_sum  = nrb_pkg::RING_W'(rd_off_r & mask) + nrb_pkg::RING_W'(nrb_pkg::RX_HDR_LEN);
  assign off      = 16'(off_sum) & mask;
  assign sum      = nrb_pkg::RING_W'(off) + nrb_pkg::RING_W'(item.rx_length);
  assign wrap     = (sum >= ring_len);
  assign seg      = ring_len - nrb_pkg::RING_W'(off);
  assign next_off = 16'(sum) & mask;
  assign rnd_sum  = nrb_pkg::RING_W'(next_off) + nrb_pkg::RING_W'(3);
  assign rounded  = {rnd_sum[15:2], 2'b00} & mask;
  assign load_sum = nrb_pkg::RING_W'(item.pointer_value) +
                    nrb_pkg::RING_W'(nrb_pkg::PTR_BACKOFF);
  assign load_off = 16'(load_sum) & mask;
  assign ec = {(item.rx_status[4] || item.rx_status[3]),
               item.rx_status[2],
               (item.rx_status[5] || item.rx_status[1])};

  always_comb begin
    rd_off_nxt  = rd_off_r;
    res         = '0;
    res.outcome = nrb_pkg::OUT_NO_CHANGE;
    case (item.cmd)
      nrb_pkg::CMD_RX_HEADER: begin
        if (item.rx_length == nrb_pkg::COPYING_MARK) begin
          res.outcome = nrb_pkg::OUT_COPYING;
        end else if (!item.rx_status[0]) begin
          res.outcome     = nrb_pkg::OUT_RX_RESET;
          res.error_class = ec;
        end else begin
          res.outcome       = nrb_pkg::OUT_DONE;
          res.data_offset   = off;
          res.first_len     = wrap ? 16'(seg) : item.rx_length;
          res.second_len    = wrap ? 16'(nrb_pkg::RING_W'(item.rx_length) - seg) : 16'd0;
          res.pointer_write = rounded - nrb_pkg::PTR_BACKOFF;
          if (fire) begin
            rd_off_nxt = rounded;
          end
        end
      end
      nrb_pkg::CMD_LOAD_PTR: begin
        res.outcome = nrb_pkg::OUT_DONE;
        if (fire) begin
          rd_off_nxt = load_off;
        end
      end
      nrb_pkg::CMD_REINIT: begin
        res.outcome = nrb_pkg::OUT_DONE;
        if (fire) begin
          rd_off_nxt = '0;
        end
      end
      default: begin
        res.outcome = nrb_pkg::OUT_NO_CHANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_off_r <= '0;
    end else begin
      rd_off_r <= rd_off_nxt;
    end
  end

endmodule

// ===== hdl/nrb_link.sv =====
// ----------------------------------------------------------------------------
// nrb_link
// Link speed tracker: follows the media status byte and reports changes.
// ----------------------------------------------------------------------------
module nrb_link (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  nrb_pkg::in_item_t item,
  output nrb_pkg::out_item_t res
);

  nrb_pkg::speed_e speed_r, speed_nxt, speed_new;
  logic changed;

  always_comb begin
    speed_new = speed_r;
    changed   = 1'b0;
    if (!item.media_status[2]) begin
      if (!item.media_status[3] && (speed_r != nrb_pkg::SPEED_100)) begin
        speed_new = nrb_pkg::SPEED_100;
        changed   = 1'b1;
      end else if (item.media_status[3] && (speed_r != nrb_pkg::SPEED_10)) begin
        speed_new = nrb_pkg::SPEED_10;
        changed   = 1'b1;
      end
    end
  end

  always_comb begin
    speed_nxt = speed_r;
    res       = '0;
    res.outcome = nrb_pkg::OUT_NO_CHANGE;
    if (item.cmd == nrb_pkg::CMD_LINK) begin
      res.outcome       = changed ? nrb_pkg::OUT_DONE : nrb_pkg::OUT_NO_CHANGE;
      res.speed_changed = changed;
      res.speed_fast    = (speed_new == nrb_pkg::SPEED_100);
      if (fire) begin
        speed_nxt = speed_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= nrb_pkg::SPEED_UNKNOWN;
    end else begin
      speed_r <= speed_nxt;
    end
  end

endmodule
